FILE: hdl/cdc_pkg.sv
// Shared types, opcodes and calendar constants for the calendar date counter.
`timescale 1ns / 1ps
`default_nettype none

package cdc_pkg;

  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 10;
  localparam int M100_W  = 7;
  localparam int M400_W  = 9;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_ADVANCE = 2'd1;
  localparam logic [1:0] OP_COMPARE = 2'd2;

  localparam logic [YEAR_W-1:0]  YEAR_MIN   = 12'd1970;
  localparam logic [YEAR_W-1:0]  YEAR_MAX   = 12'd2035;
  localparam logic [YEAR_W-1:0]  YEAR_TOP   = 12'd4095;
  localparam logic [YEAR_W-1:0]  YEAR_2000  = 12'd2000;
  localparam logic [YEAR_W-1:0]  YEAR_1900  = 12'd1900;
  localparam logic [YEAR_W-1:0]  YEAR_1600  = 12'd1600;
  localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
  localparam logic [M100_W-1:0]  M100_WRAP  = 7'd99;
  localparam logic [M400_W-1:0]  M400_WRAP  = 9'd399;
  localparam logic [M100_W-1:0]  M100_RESET = 7'd70;
  localparam logic [M400_W-1:0]  M400_RESET = 9'd370;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;   // an input item is accepted this cycle
    logic step;      // take one day step of a running advance
  } cdc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic adv_start; // the presented item is an advance of at least one day
    logic adv_done;  // the running advance ends with this step
  } cdc_sts_t;

  // Length of a month; months outside 1..12 read as 31.
  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                               input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                   len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/cdc_if.sv
// Valid/ready channel interfaces for the input items and the result items.
`timescale 1ns / 1ps
`default_nettype none

interface cdc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [11:0] in_year;
  logic [3:0]  in_month;
  logic [4:0]  in_day;
  logic [9:0]  day_count;

  modport source(output valid, opcode, in_year, in_month, in_day, day_count,
                 input ready);
  modport sink(input valid, opcode, in_year, in_month, in_day, day_count,
               output ready);
endinterface

interface cdc_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic        load_rejected;
  logic        saturated;
  logic        stored_before;
  logic        stored_equal;
  logic        stored_after;

  modport source(output valid, out_year, out_month, out_day, load_rejected,
                 saturated, stored_before, stored_equal, stored_after,
                 input ready);
  modport sink(input valid, out_year, out_month, out_day, load_rejected,
               saturated, stored_before, stored_equal, stored_after,
               output ready);
endinterface

`default_nettype wire

FILE: hdl/cdc_ctrl.sv
// Controller state machine: handshakes and sequencing of the day steps.
`timescale 1ns / 1ps
`default_nettype none

module cdc_ctrl
  import cdc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire cdc_sts_t sts,
  output cdc_cmd_t      cmd
);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_set;

  always_comb begin
    in_ready    = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
    cmd.load_in = in_valid && in_ready;
    cmd.step    = (state_r == ST_RUN);
    // A result item is ready when an item that needs no day step is accepted or
    // when the last day step of an advance is taken.
    out_set     = ((state_r == ST_IDLE) && cmd.load_in && !sts.adv_start) ||
                  ((state_r == ST_RUN) && sts.adv_done);
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_set) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (cmd.load_in && sts.adv_start) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (sts.adv_done) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/cdc_dp.sv
// Datapath: stored date, leap tracking, day stepper, compare and result register.
`timescale 1ns / 1ps
`default_nettype none

module cdc_dp
  import cdc_pkg::*;
#(
  parameter int unsigned MAX_ADVANCE = 1023
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cdc_cmd_t           cmd,
  output cdc_sts_t                sts,
  input  wire logic [1:0]         opcode,
  input  wire logic [YEAR_W-1:0]  in_year,
  input  wire logic [MONTH_W-1:0] in_month,
  input  wire logic [DAY_W-1:0]   in_day,
  input  wire logic [COUNT_W-1:0] day_count,
  output logic [YEAR_W-1:0]       out_year,
  output logic [MONTH_W-1:0]      out_month,
  output logic [DAY_W-1:0]        out_day,
  output logic                    load_rejected,
  output logic                    saturated,
  output logic                    stored_before,
  output logic                    stored_equal,
  output logic                    stored_after
);

  localparam int CMP_W = COUNT_W + 7;

  logic [YEAR_W-1:0]  year_r,  year_nxt;
  logic [MONTH_W-1:0] month_r, month_nxt;
  logic [DAY_W-1:0]   day_r,   day_nxt;
  logic [M100_W-1:0]  m100_r,  m100_nxt;
  logic [M400_W-1:0]  m400_r,  m400_nxt;
  logic [COUNT_W-1:0] cnt_r;

  logic [YEAR_W-1:0]  oyear_r;
  logic [MONTH_W-1:0] omonth_r;
  logic [DAY_W-1:0]   oday_r;
  logic               orej_r, osat_r, olt_r, oeq_r, ogt_r;

  logic [COUNT_W-1:0] n_clamp;
  logic               in_leap, in_ok, do_load;
  logic [YEAR_W-1:0]  in_off100, in_off400;
  logic               cur_leap, month_end, at_top;
  logic [DAY_W-1:0]   cur_len;
  logic [YEAR_W+MONTH_W+DAY_W-1:0] key_cur, key_in;

  always_comb begin
    if ({{(CMP_W-COUNT_W){1'b0}}, day_count} > CMP_W'(MAX_ADVANCE)) begin
      n_clamp = COUNT_W'(MAX_ADVANCE);
    end else begin
      n_clamp = day_count;
    end

    // Inside 1970..2035 the only century year is 2000, a leap year.
    in_leap = (in_year[1:0] == 2'b00);
    in_ok   = (in_year >= YEAR_MIN) && (in_year <= YEAR_MAX) &&
              (in_month >= MONTH_JAN) && (in_month <= MONTH_DEC) &&
              (in_day >= DAY_FIRST) && (in_day <= days_in(in_month, in_leap));
    do_load = cmd.load_in && (opcode == OP_LOAD) && in_ok;

    if (in_year >= YEAR_2000) begin
      in_off100 = in_year - YEAR_2000;
      in_off400 = in_year - YEAR_2000;
    end else begin
      in_off100 = in_year - YEAR_1900;
      in_off400 = in_year - YEAR_1600;
    end

    cur_leap  = (m400_r == '0) || ((m100_r != '0) && (year_r[1:0] == 2'b00));
    cur_len   = days_in(month_r, cur_leap);
    month_end = (day_r >= cur_len);
    at_top    = month_end && (month_r >= MONTH_DEC) && (year_r == YEAR_TOP);

    sts.adv_start = (opcode == OP_ADVANCE) && (n_clamp != '0);
    sts.adv_done  = at_top || (cnt_r == COUNT_W'(1));

    key_cur = {year_r, month_r, day_r};
    key_in  = {in_year, in_month, in_day};

    year_nxt  = year_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    m100_nxt  = m100_r;
    m400_nxt  = m400_r;
    if (do_load) begin
      year_nxt  = in_year;
      month_nxt = in_month;
      day_nxt   = in_day;
      m100_nxt  = in_off100[M100_W-1:0];
      m400_nxt  = in_off400[M400_W-1:0];
    end else if (cmd.step && !at_top) begin
      if (month_end) begin
        day_nxt = DAY_FIRST;
        if (month_r >= MONTH_DEC) begin
          year_nxt  = year_r + 1'b1;
          month_nxt = MONTH_JAN;
          m100_nxt  = (m100_r == M100_WRAP) ? '0 : m100_r + 1'b1;
          m400_nxt  = (m400_r == M400_WRAP) ? '0 : m400_r + 1'b1;
        end else begin
          month_nxt = month_r + 1'b1;
        end
      end else begin
        day_nxt = day_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r  <= YEAR_MIN;
      month_r <= MONTH_JAN;
      day_r   <= DAY_FIRST;
      m100_r  <= M100_RESET;
      m400_r  <= M400_RESET;
    end else begin
      year_r  <= year_nxt;
      month_r <= month_nxt;
      day_r   <= day_nxt;
      m100_r  <= m100_nxt;
      m400_r  <= m400_nxt;
    end
  end

  // Day counter and result register.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cnt_r <= n_clamp;
    end else if (cmd.step) begin
      cnt_r <= cnt_r - 1'b1;
    end

    if (cmd.load_in && !sts.adv_start) begin
      oyear_r  <= year_nxt;
      omonth_r <= month_nxt;
      oday_r   <= day_nxt;
      orej_r   <= (opcode == OP_LOAD) && !in_ok;
      osat_r   <= 1'b0;
      olt_r    <= (opcode == OP_COMPARE) && (key_cur < key_in);
      oeq_r    <= (opcode == OP_COMPARE) && (key_cur == key_in);
      ogt_r    <= (opcode == OP_COMPARE) && (key_cur > key_in);
    end else if (cmd.step && sts.adv_done) begin
      oyear_r  <= year_nxt;
      omonth_r <= month_nxt;
      oday_r   <= day_nxt;
      orej_r   <= 1'b0;
      osat_r   <= at_top;
      olt_r    <= 1'b0;
      oeq_r    <= 1'b0;
      ogt_r    <= 1'b0;
    end
  end

  assign out_year      = oyear_r;
  assign out_month     = omonth_r;
  assign out_day       = oday_r;
  assign load_rejected = orej_r;
  assign saturated     = osat_r;
  assign stored_before = olt_r;
  assign stored_equal  = oeq_r;
  assign stored_after  = ogt_r;

endmodule

`default_nettype wire

FILE: hdl/calendar_date_counter_top.sv
// Top level of the calendar date counter: controller, datapath and checks.
// Timing: load, compare and unused opcodes put their result item in the output
//   register in the cycle after acceptance; an advance of n days (n clamped to
//   MAX_ADVANCE) takes n day steps, fewer on saturation.
// Throughput: one item per cycle for load and compare while the output side takes
//   each result; an advance holds off new items until its last day step.
// Reset: synchronous, active low; the stored date returns to 1970-01-01.
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_counter_top
  import cdc_pkg::*;
#(
  parameter int unsigned MAX_ADVANCE = 1023
) (
  input wire logic clk,
  input wire logic rst_n,
  cdc_in_if.sink   in_ch,
  cdc_out_if.source out_ch
);

  // The controller owns both handshakes. It accepts a new item whenever it
  // is not stepping an advance and the output register is empty or is being
  // drained in the same cycle, so a result that is being taken never blocks
  // a new item.
  cdc_cmd_t cmd;
  cdc_sts_t sts;

  cdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the date, tracks the year modulo 100 and 400 so the
  // full leap rule needs no divider, and moves one day per step command.
  cdc_dp #(
    .MAX_ADVANCE (MAX_ADVANCE)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .opcode        (in_ch.opcode),
    .in_year       (in_ch.in_year),
    .in_month      (in_ch.in_month),
    .in_day        (in_ch.in_day),
    .day_count     (in_ch.day_count),
    .out_year      (out_ch.out_year),
    .out_month     (out_ch.out_month),
    .out_day       (out_ch.out_day),
    .load_rejected (out_ch.load_rejected),
    .saturated     (out_ch.saturated),
    .stored_before (out_ch.stored_before),
    .stored_equal  (out_ch.stored_equal),
    .stored_after  (out_ch.stored_after)
  );

  // No new item may enter while an advance is being stepped.
  a_no_accept_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !in_ch.ready)
    else $error("input accepted during an advance");

  // An accepted advance of at least one day starts stepping in the next cycle.
  a_run_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_in && sts.adv_start) |=> cmd.step)
    else $error("advance did not start stepping");

  // Saturation is only reported at the greatest representable date.
  a_sat_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.saturated) |->
      (out_ch.out_year == YEAR_TOP && out_ch.out_month == MONTH_DEC &&
       out_ch.out_day == 5'd31))
    else $error("saturation flagged below the top date");

  // At most one flag is set in any result item.
  a_flags_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> $onehot0({out_ch.load_rejected, out_ch.saturated,
                               out_ch.stored_before, out_ch.stored_equal,
                               out_ch.stored_after}))
    else $error("more than one result flag set");

endmodule

`default_nettype wire

FILE: test/calendar_date_counter_top_tb.sv
// Self-checking testbench for the calendar date counter: random and directed date items.
`timescale 1ns / 1ps

package cdc_tb_pkg;
  import cdc_pkg::*;

  localparam int unsigned ADVANCE_LIMIT = 1023;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [COUNT_W-1:0] day_count;
  } date_cmd_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               load_rejected;
    logic               saturated;
    logic               stored_before;
    logic               stored_equal;
    logic               stored_after;
  } date_report_t;

  // Tracks the stored date and holds the reports still owed by the block.
  class date_scoreboard;
    logic [YEAR_W-1:0]  year  = YEAR_MIN;
    logic [MONTH_W-1:0] month = MONTH_JAN;
    logic [DAY_W-1:0]   day   = DAY_FIRST;
    date_report_t expected_dates[$];
    int unsigned errors, items, loads, rejects, advances, saturations;
    int unsigned compares, equal_hits, unused_ops, days_stepped;

    function bit leap_year(logic [YEAR_W-1:0] y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function int unsigned month_length(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m);
      case (m)
        4'd2:                    return leap_year(y) ? 29 : 28;
        4'd4, 4'd6, 4'd9, 4'd11: return 30;
        default:                 return 31;
      endcase
    endfunction

    function bit date_is_valid(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                               logic [DAY_W-1:0] d);
      return y >= YEAR_MIN && y <= YEAR_MAX && m >= MONTH_JAN && m <= MONTH_DEC &&
             d >= DAY_FIRST && d <= month_length(y, m);
    endfunction

    // Moves the date one day on; returns 0 when already at the last date.
    function bit step_one_day();
      if (day >= month_length(year, month)) begin
        if (month >= MONTH_DEC) begin
          if (year >= YEAR_TOP) return 1'b0;
          year  = year + 1'b1;
          month = MONTH_JAN;
        end else begin
          month = month + 1'b1;
        end
        day = DAY_FIRST;
      end else begin
        day = day + 1'b1;
      end
      return 1'b1;
    endfunction

    function void predict_date_step(date_cmd_t c);
      date_report_t r;
      int unsigned steps;
      r = '0;
      items++;
      case (c.opcode)
        OP_LOAD: begin
          loads++;
          if (date_is_valid(c.year, c.month, c.day)) begin
            year  = c.year;
            month = c.month;
            day   = c.day;
          end else begin
            r.load_rejected = 1'b1;
            rejects++;
          end
        end
        OP_ADVANCE: begin
          advances++;
          steps = (c.day_count > ADVANCE_LIMIT) ? ADVANCE_LIMIT : c.day_count;
          while (steps > 0 && !r.saturated) begin
            if (step_one_day()) days_stepped++;
            else r.saturated = 1'b1;
            steps--;
          end
          if (r.saturated) saturations++;
        end
        OP_COMPARE: begin
          compares++;
          r.stored_before = {year, month, day} <  {c.year, c.month, c.day};
          r.stored_equal  = {year, month, day} == {c.year, c.month, c.day};
          r.stored_after  = {year, month, day} >  {c.year, c.month, c.day};
          if (r.stored_equal) equal_hits++;
        end
        default: unused_ops++;
      endcase
      r.year  = year;
      r.month = month;
      r.day   = day;
      expected_dates.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_report(date_report_t got);
      date_report_t want;
      if (expected_dates.size() == 0) begin
        $error("result item %0d-%0d-%0d arrived with nothing expected",
               got.year, got.month, got.day);
        errors++;
        return;
      end
      want = expected_dates.pop_front();
      check_field("out_year", 32'(want.year), 32'(got.year));
      check_field("out_month", 32'(want.month), 32'(got.month));
      check_field("out_day", 32'(want.day), 32'(got.day));
      check_field("load_rejected", 32'(want.load_rejected), 32'(got.load_rejected));
      check_field("saturated", 32'(want.saturated), 32'(got.saturated));
      check_field("stored_before", 32'(want.stored_before), 32'(got.stored_before));
      check_field("stored_equal", 32'(want.stored_equal), 32'(got.stored_equal));
      check_field("stored_after", 32'(want.stored_after), 32'(got.stored_after));
    endfunction
  endclass

endpackage

module calendar_date_counter_top_tb;
  import cdc_pkg::*;
  import cdc_tb_pkg::*;

  // Each side waits a random gap, at most MAX_GAP, per item. The watchdog limit
  // covers the longest advance plus both sides' longest waits, taken four times over.
  localparam int unsigned MAX_GAP       = 9;
  localparam int unsigned STALL_LIMIT   = 4 * (ADVANCE_LIMIT + 1 + 2 * MAX_GAP + 8);
  localparam int unsigned RANDOM_ITEMS  = 560;
  localparam int unsigned SETTLE_CYCLES = 20;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // When set, neither side idles, so the block sees back-to-back traffic.
  bit quiet_stretch = 1'b0;
  int unsigned idle_cycles = 0;
  date_scoreboard sb = new;

  cdc_in_if  in_ch();
  cdc_out_if out_ch();

  calendar_date_counter_top #(.MAX_ADVANCE(ADVANCE_LIMIT)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic date_cmd_t make_cmd(logic [1:0] op, int unsigned y, int unsigned m,
                                         int unsigned d, int unsigned n);
    date_cmd_t c;
    c.opcode    = op;
    c.year      = YEAR_W'(y);
    c.month     = MONTH_W'(m);
    c.day       = DAY_W'(d);
    c.day_count = COUNT_W'(n);
    return c;
  endfunction

  // Builds one random item. Fields that the opcode ignores carry noise.
  // Loads are mostly well-formed dates, and compares are often aimed at
  // the stored date so that equality and near misses come up regularly.
  function automatic date_cmd_t random_cmd();
    date_cmd_t c;
    int unsigned pick;
    int unsigned shape;
    c.year      = YEAR_W'($urandom_range(0, 4095));
    c.month     = MONTH_W'($urandom_range(0, 15));
    c.day       = DAY_W'($urandom_range(0, 31));
    c.day_count = COUNT_W'($urandom_range(0, 1023));
    pick  = $urandom_range(0, 99);
    shape = $urandom_range(0, 9);
    if (pick < 32) begin
      c.opcode = OP_LOAD;
      if (shape < 6) begin
        c.year  = YEAR_W'($urandom_range(YEAR_MIN, YEAR_MAX));
        c.month = MONTH_W'($urandom_range(1, 12));
        c.day   = DAY_W'($urandom_range(1, sb.month_length(c.year, c.month)));
      end else if (shape < 7) begin
        // February 29 of any year in range: accepted only in leap years.
        c.year  = YEAR_W'($urandom_range(YEAR_MIN, YEAR_MAX));
        c.month = 4'd2;
        c.day   = 5'd29;
      end
    end else if (pick < 64) begin
      c.opcode = OP_ADVANCE;
      // Most advances are short so that the run stays fast.
      if ($urandom_range(0, 3) != 0) c.day_count = COUNT_W'($urandom_range(0, 40));
    end else if (pick < 92) begin
      c.opcode = OP_COMPARE;
      if (shape < 7) begin
        c.year  = sb.year;
        c.month = sb.month;
        c.day   = sb.day;
      end
      // Near misses: one field off by its lowest bit.
      if (shape >= 4 && shape < 7) begin
        case ($urandom_range(0, 2))
          0:       c.year  = c.year ^ 12'd1;
          1:       c.month = c.month ^ 4'd1;
          default: c.day   = c.day ^ 5'd1;
        endcase
      end
    end else begin
      c.opcode = OP_UNUSED;
    end
    return c;
  endfunction

  // Presents one item after a random gap and returns once it is accepted.
  // Valid is lowered only when a gap follows, so it never drops and rises
  // within one time step.
  task automatic send_cmd(input date_cmd_t c);
    int unsigned gap;
    gap = quiet_stretch ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= c.opcode;
    in_ch.in_year   <= c.year;
    in_ch.in_month  <= c.month;
    in_ch.in_day    <= c.day;
    in_ch.day_count <= c.day_count;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.predict_date_step(c);
  endtask

  // Holds the input side off until every owed result item has come back.
  task automatic hold_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.expected_dates.size() != 0) @(negedge clk);
  endtask

  // Result side: random back-pressure per item, sampled at the rising edge.
  initial begin : result_sink
    date_report_t got;
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = quiet_stretch ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got.year          = out_ch.out_year;
      got.month         = out_ch.out_month;
      got.day           = out_ch.out_day;
      got.load_rejected = out_ch.load_rejected;
      got.saturated     = out_ch.saturated;
      got.stored_before = out_ch.stored_before;
      got.stored_equal  = out_ch.stored_equal;
      got.stored_after  = out_ch.stored_after;
      sb.check_report(got);
    end
  end

  // The run ends if no item moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $error("no item moved for %0d cycles, %0d results owed",
             idle_cycles, sb.expected_dates.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned k;
    in_ch.valid     = 1'b0;
    in_ch.opcode    = OP_LOAD;
    in_ch.in_year   = '0;
    in_ch.in_month  = '0;
    in_ch.in_day    = '0;
    in_ch.day_count = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. The reset date is checked first, then the limits of
    // load validation, including the leap rules and month lengths.
    send_cmd(make_cmd(OP_COMPARE, 1970, 1, 1, 0));
    send_cmd(make_cmd(OP_LOAD, 2035, 12, 31, 0));
    send_cmd(make_cmd(OP_LOAD, 1970, 1, 1, 0));
    send_cmd(make_cmd(OP_LOAD, 1969, 12, 31, 0));
    send_cmd(make_cmd(OP_LOAD, 2036, 1, 1, 0));
    send_cmd(make_cmd(OP_LOAD, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_LOAD, 4095, 15, 31, 1023));
    send_cmd(make_cmd(OP_LOAD, 2000, 13, 1, 0));
    send_cmd(make_cmd(OP_LOAD, 2000, 4, 31, 0));
    // 2000 is a leap year by the 400 rule.
    send_cmd(make_cmd(OP_LOAD, 2000, 2, 29, 0));
    send_cmd(make_cmd(OP_ADVANCE, 0, 0, 0, 1));
    send_cmd(make_cmd(OP_LOAD, 2001, 2, 29, 0));
    send_cmd(make_cmd(OP_LOAD, 2024, 2, 30, 0));
    // Stepping through a leap February, then across a year boundary.
    send_cmd(make_cmd(OP_LOAD, 2024, 1, 31, 0));
    send_cmd(make_cmd(OP_ADVANCE, 0, 0, 0, 29));
    send_cmd(make_cmd(OP_LOAD, 2023, 12, 31, 0));
    send_cmd(make_cmd(OP_ADVANCE, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_ADVANCE, 0, 0, 0, 1));
    send_cmd(make_cmd(OP_ADVANCE, 4095, 15, 31, 1023));
    // Compare inputs are not validated, so out-of-range fields still order.
    send_cmd(make_cmd(OP_COMPARE, 4095, 15, 31, 0));
    send_cmd(make_cmd(OP_COMPARE, 0, 0, 0, 1023));
    send_cmd(make_cmd(OP_UNUSED, 4095, 15, 31, 1023));
    hold_until_drained();

    // Random part, with stretches of back-to-back traffic and a few pauses
    // in which the input side waits for the result side to catch up.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 40 == 0) quiet_stretch = ($urandom_range(0, 3) == 0);
      if (k % 150 == 75) hold_until_drained();
      send_cmd(random_cmd());
    end
    quiet_stretch = 1'b0;
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d items: %0d loads (%0d rejected), %0d advances over %0d days",
             sb.items, sb.loads, sb.rejects, sb.advances, sb.days_stepped);
    $display("  with %0d saturated, %0d compares (%0d equal), %0d unused opcodes",
             sb.saturations, sb.compares, sb.equal_hits, sb.unused_ops);
    if (sb.errors == 0 && sb.expected_dates.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
